@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the line draw frame store RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ldfs_pkg.sv @@
// Types and codes shared by the line draw frame store modules.
package ldfs_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PLOT  = 2'd1,
    OP_LINE  = 2'd2,
    OP_READ  = 2'd3
  } ldfs_op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_PLOT,
    ST_READ,
    ST_LINE_SETUP,
    ST_LINE,
    ST_FINISH
  } ldfs_state_t;

  typedef struct packed {
    ldfs_op_t    op;
    logic [7:0]  start_x;
    logic [7:0]  start_y;
    logic [7:0]  end_x;
    logic [7:0]  end_y;
    logic [23:0] pen_color;
  } ldfs_in_t;

  typedef struct packed {
    logic [23:0] read_color;
    logic        pixel_inside;
  } ldfs_out_t;

  typedef struct packed {
    logic load;
    logic line_setup;
    logic line_step;
    logic clr_step;
    logic plot_wr;
    logic rd_en;
    logic out_load;
  } ldfs_cmd_t;

  typedef struct packed {
    ldfs_op_t in_op;
    logic     line_last;
    logic     clr_last;
    logic     out_free;
  } ldfs_status_t;

endpackage

@@ rtl/core/ldfs_ctrl.sv @@
// Command sequencer for the line draw frame store.
`include "assert_macros.svh"

module ldfs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ldfs_pkg::ldfs_status_t st,
  output ldfs_pkg::ldfs_cmd_t    cmd
);

  ldfs_pkg::ldfs_state_t state_r;
  ldfs_pkg::ldfs_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldfs_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ldfs_pkg::ST_INIT: begin
        if (st.clr_last) state_nxt = ldfs_pkg::ST_IDLE;
      end
      ldfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (st.in_op)
            ldfs_pkg::OP_CLEAR: state_nxt = ldfs_pkg::ST_CLEAR;
            ldfs_pkg::OP_PLOT:  state_nxt = ldfs_pkg::ST_PLOT;
            ldfs_pkg::OP_LINE:  state_nxt = ldfs_pkg::ST_LINE_SETUP;
            ldfs_pkg::OP_READ:  state_nxt = ldfs_pkg::ST_READ;
            default:            state_nxt = ldfs_pkg::ST_IDLE;
          endcase
        end
      end
      ldfs_pkg::ST_CLEAR: begin
        if (st.clr_last) state_nxt = ldfs_pkg::ST_FINISH;
      end
      ldfs_pkg::ST_PLOT:       state_nxt = ldfs_pkg::ST_FINISH;
      ldfs_pkg::ST_READ:       state_nxt = ldfs_pkg::ST_FINISH;
      ldfs_pkg::ST_LINE_SETUP: state_nxt = ldfs_pkg::ST_LINE;
      ldfs_pkg::ST_LINE: begin
        if (st.line_last) state_nxt = ldfs_pkg::ST_FINISH;
      end
      ldfs_pkg::ST_FINISH: begin
        if (st.out_free) state_nxt = ldfs_pkg::ST_IDLE;
      end
      default: state_nxt = ldfs_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ldfs_pkg::ST_INIT:  cmd.clr_step = 1'b1;
      ldfs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ldfs_pkg::ST_CLEAR:      cmd.clr_step   = 1'b1;
      ldfs_pkg::ST_PLOT:       cmd.plot_wr    = 1'b1;
      ldfs_pkg::ST_READ:       cmd.rd_en      = 1'b1;
      ldfs_pkg::ST_LINE_SETUP: cmd.line_setup = 1'b1;
      ldfs_pkg::ST_LINE:       cmd.line_step  = 1'b1;
      ldfs_pkg::ST_FINISH:     cmd.out_load   = st.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  `ASSERT_IMP(a_out_load_free, clk, rst_n, cmd.out_load, st.out_free,
              "result loaded while output register busy")
  `ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready,
              state_r != ldfs_pkg::ST_IDLE, "accepted transaction did not start work")
  `ASSERT_IMP(a_one_writer, clk, rst_n, 1'b1,
              $onehot0({cmd.plot_wr, cmd.line_step, cmd.clr_step}),
              "more than one store writer active")

endmodule

@@ rtl/core/ldfs_datapath.sv @@
// Frame store, line stepper, clear sweep and result register.
`include "assert_macros.svh"

module ldfs_datapath #(
  parameter int FRAME_WIDTH  = 128,
  parameter int FRAME_HEIGHT = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ldfs_pkg::ldfs_in_t     in_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output ldfs_pkg::ldfs_out_t    out_data,
  input  ldfs_pkg::ldfs_cmd_t    cmd,
  output ldfs_pkg::ldfs_status_t st
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [23:0]        mem [DEPTH];

  ldfs_pkg::ldfs_in_t cmd_r;
  logic [23:0]        mem_q_r;
  logic               out_valid_r;
  ldfs_pkg::ldfs_out_t out_data_r;
  ldfs_pkg::ldfs_out_t out_data_nxt;
  logic [9:0]         px_r, py_r, px_nxt, py_nxt;
  logic [8:0]         ex_r, ey_r, ex_nxt, ey_nxt;
  logic [7:0]         dx_r, dy_r, span_r;
  logic               sx_en_r, sx_neg_r, sy_en_r, sy_neg_r;
  logic [8:0]         k_r;
  logic [AW-1:0]      clr_cnt_r;

  logic [8:0]  dx_full, dy_full;
  logic [7:0]  adx, ady;
  logic [8:0]  ex_sum, ey_sum;
  logic        ex_gt, ey_gt;
  logic        start_in, line_in, clr_last, line_last;
  logic [7:0]  sel_x, sel_y;
  logic [16:0] lin_addr;
  logic [AW-1:0] mem_addr;
  logic        mem_we;
  logic [23:0] mem_wdata;

  // Line setup: absolute deltas and directions.
  assign dx_full = {1'b0, cmd_r.end_x} - {1'b0, cmd_r.start_x};
  assign dy_full = {1'b0, cmd_r.end_y} - {1'b0, cmd_r.start_y};
  assign adx     = dx_full[8] ? 8'(~dx_full + 9'd1) : dx_full[7:0];
  assign ady     = dy_full[8] ? 8'(~dy_full + 9'd1) : dy_full[7:0];

  // Error accumulator step.
  assign ex_sum = ex_r + 9'(dx_r);
  assign ey_sum = ey_r + 9'(dy_r);
  assign ex_gt  = ex_sum > 9'(span_r);
  assign ey_gt  = ey_sum > 9'(span_r);
  assign ex_nxt = ex_gt ? ex_sum - 9'(span_r) : ex_sum;
  assign ey_nxt = ey_gt ? ey_sum - 9'(span_r) : ey_sum;
  assign px_nxt = (ex_gt && sx_en_r) ? px_r + (sx_neg_r ? 10'h3FF : 10'd1) : px_r;
  assign py_nxt = (ey_gt && sy_en_r) ? py_r + (sy_neg_r ? 10'h3FF : 10'd1) : py_r;

  assign line_last = k_r == (9'(span_r) + 9'd1);
  assign clr_last  = clr_cnt_r == AW'(DEPTH - 1);

  assign start_in = ({1'b0, cmd_r.start_x} < 9'(FRAME_WIDTH)) &&
                    ({1'b0, cmd_r.start_y} < 9'(FRAME_HEIGHT));
  assign line_in  = !px_r[9] && !py_r[9] &&
                    (px_r[8:0] < 9'(FRAME_WIDTH)) && (py_r[8:0] < 9'(FRAME_HEIGHT));

  assign sel_x    = cmd.line_step ? px_r[7:0] : cmd_r.start_x;
  assign sel_y    = cmd.line_step ? py_r[7:0] : cmd_r.start_y;
  assign lin_addr = 17'(sel_y) * 17'(FRAME_WIDTH) + 17'(sel_x);
  assign mem_addr = cmd.clr_step ? clr_cnt_r : AW'(lin_addr);
  assign mem_we   = cmd.clr_step || (cmd.plot_wr && start_in) ||
                    (cmd.line_step && line_in);
  assign mem_wdata = cmd.clr_step ? 24'd0 : cmd_r.pen_color;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (cmd.rd_en) mem_q_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) cmd_r <= in_data;
    if (cmd.line_setup) begin
      dx_r     <= adx;
      dy_r     <= ady;
      span_r   <= (adx > ady) ? adx : ady;
      sx_en_r  <= adx != 8'd0;
      sx_neg_r <= dx_full[8];
      sy_en_r  <= ady != 8'd0;
      sy_neg_r <= dy_full[8];
      ex_r     <= 9'd0;
      ey_r     <= 9'd0;
      px_r     <= {2'b00, cmd_r.start_x};
      py_r     <= {2'b00, cmd_r.start_y};
      k_r      <= 9'd0;
    end else if (cmd.line_step) begin
      ex_r <= ex_nxt;
      ey_r <= ey_nxt;
      px_r <= px_nxt;
      py_r <= py_nxt;
      k_r  <= k_r + 9'd1;
    end
    if (cmd.out_load) out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_last ? '0 : clr_cnt_r + AW'(1);
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    out_data_nxt.read_color   = (cmd_r.op == ldfs_pkg::OP_READ && start_in) ?
                                mem_q_r : 24'd0;
    out_data_nxt.pixel_inside = start_in && (cmd_r.op == ldfs_pkg::OP_PLOT ||
                                             cmd_r.op == ldfs_pkg::OP_READ);
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign st.in_op     = in_data.op;
  assign st.line_last = line_last;
  assign st.clr_last  = clr_last;
  assign st.out_free  = !out_valid_r || out_ready;

  `ASSERT_IMP(a_we_in_range, clk, rst_n, mem_we, mem_addr <= AW'(DEPTH - 1),
              "store write beyond frame")
  `ASSERT_NXT(a_clr_wrap, clk, rst_n, cmd.clr_step && clr_last, clr_cnt_r == '0,
              "clear sweep did not wrap")

endmodule

@@ rtl/core/line_draw_frame_store_unit.sv @@
// Top level of the line draw frame store: sequencer plus datapath.
// Drawing engine over a FRAME_WIDTH x FRAME_HEIGHT store of 24-bit RGB pixels,
// one command per transaction and one result per command. After reset the
// store is swept to zero, one pixel per cycle, with in_ready low, over all
// FRAME_WIDTH*FRAME_HEIGHT pixels (8192 at the defaults). Clear runs the same
// sweep. Plot and read each access the store once (the read goes through the
// registered store read port). For a line, span is the larger absolute delta:
// one store write port handles one pixel per cycle for span+2 steps, all
// clipped to the frame. Commands are worked one at a time; a new one may be
// accepted while the previous result waits in the output register.
module line_draw_frame_store_unit #(
  parameter int FRAME_WIDTH  = 128,
  parameter int FRAME_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ldfs_pkg::ldfs_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ldfs_pkg::ldfs_out_t out_data
);

  ldfs_pkg::ldfs_cmd_t    cmd;
  ldfs_pkg::ldfs_status_t st;

  ldfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ldfs_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
